[rtl/mrmp_pkg.sv]
// Package: shared types, constants and CRC helper for the meter poller.
`timescale 1ns / 1ps
package mrmp_pkg;

  localparam int unsigned NUM_SLOTS = 12;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned ReplyLen  = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_UPD = 2'd1;
  localparam logic [1:0] KIND_PUB = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ADDR    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AGE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PUBINT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ABSENT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PROBE   = 3'd6;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  BYTE_COUNT      = 8'h04;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [31:0] FLOAT_ONE       = 32'h3F80_0000;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       tx_byte;
    logic             last;
    logic [SlotW-1:0] reg_slot;
    logic [31:0]      value_bits;
    logic [1:0]       active_phases;
    logic             meter_absent;
    logic [15:0]      error_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_ENDX, ST_TX, ST_UPD, ST_PUB
  } state_e;

  typedef struct packed {
    logic       exec;
    logic       endx;
    logic       emit;
    logic [1:0] emit_kind;
  } cmd_t;

  typedef struct packed {
    logic end_x;
    logic send;
    logic upd;
    logic pub;
    logic tx_last;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] slot_reg(input logic [SlotW-1:0] s);
    logic [15:0] r;
    case (s)
      4'd0:  r = 16'h0000;
      4'd1:  r = 16'h0002;
      4'd2:  r = 16'h0004;
      4'd3:  r = 16'h0006;
      4'd4:  r = 16'h0008;
      4'd5:  r = 16'h000A;
      4'd6:  r = 16'h000C;
      4'd7:  r = 16'h000E;
      4'd8:  r = 16'h0010;
      4'd9:  r = 16'h0034;
      4'd10: r = 16'h0048;
      4'd11: r = 16'h0156;
      4'd12: r = 16'h0158;
      4'd13: r = 16'h015A;
      4'd14: r = 16'h015C;
      4'd15: r = 16'h015E;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

[rtl/mrmp_datapath.sv]
// Datapath: configuration, poll state, reply checking, value store and result register.
`timescale 1ns / 1ps
module mrmp_datapath import mrmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_take_i,
  input  in_t                 in_data_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output out_t                out_data_o
);

  logic [7:0]  addr_q;
  logic [15:0] tmo_q, gap_q, age_lim_q, pub_int_q, abs_lim_q, probe_q;

  in_t              item_q;
  logic [SlotW-1:0] slot_q;
  logic             await_q, absent_q, upd_q, pub_q, out_valid_q;
  logic [3:0]       cnt_q;
  logic [15:0]      wait_q, delay_q, sgr_q, since_pub_q, err_q, rx_crc_q, tx_crc_q;
  logic [7:0]       buf_q [8];
  logic [31:0]      val_q [NUM_SLOTS];
  logic             seen_q [NUM_SLOTS];
  logic [15:0]      age_q [NUM_SLOTS];
  logic [2:0]       tx_idx_q;
  out_t             out_q, out_d;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Exec-phase decode
  logic [15:0] wait_n, delay_n;
  logic        timeout, send, byte_ok, done9, good, nan, store;
  logic [31:0] word;
  assign wait_n  = sat_inc(wait_q);
  assign delay_n = (delay_q != 16'd0) ? delay_q - 16'd1 : delay_q;
  assign timeout = !item_q.op && await_q && (wait_n >= tmo_q);
  assign send    = !item_q.op && !await_q && (delay_n == 16'd0);
  assign byte_ok = item_q.op && await_q && (cnt_q < 4'(ReplyLen));
  assign done9   = byte_ok && (cnt_q == 4'(ReplyLen - 1));
  assign word    = {buf_q[3], buf_q[4], buf_q[5], buf_q[6]};
  assign good    = (buf_q[0] == addr_q) && (buf_q[1] == FUNC_READ_INPUT) &&
                   (buf_q[2] == BYTE_COUNT) && (buf_q[7] == rx_crc_q[7:0]) &&
                   (item_q.rx_byte == rx_crc_q[15:8]);
  assign nan     = (word[30:23] == 8'hFF) && (word[22:0] != 23'd0);
  assign store   = done9 && good && !nan;

  // End-of-exchange decode
  logic             absent_n, fresh, pub_now;
  logic [SlotW-1:0] slot_n;
  always_comb begin
    fresh = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!seen_q[i] || age_q[i] > age_lim_q) fresh = 1'b0;
    end
  end
  assign absent_n = absent_q || (sgr_q >= abs_lim_q);
  assign slot_n   = (slot_q == SlotW'(NUM_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign pub_now  = !absent_n && (slot_n == '0) && fresh && (since_pub_q >= pub_int_q);

  // Phase count from the stored words of slots 3 to 5
  logic [1:0] phases;
  always_comb begin
    phases = 2'd0;
    for (int i = 3; i <= 5; i++) begin
      if (i < NUM_SLOTS) begin
        if (!val_q[i][31] && val_q[i] > FLOAT_ONE) phases = phases + 2'd1;
      end
    end
  end

  logic [15:0] req_reg;
  logic [7:0]  tx_byte;
  assign req_reg = slot_reg(slot_q);
  always_comb begin
    case (tx_idx_q)
      3'd0:    tx_byte = addr_q;
      3'd1:    tx_byte = FUNC_READ_INPUT;
      3'd2:    tx_byte = req_reg[15:8];
      3'd3:    tx_byte = req_reg[7:0];
      3'd4:    tx_byte = 8'h00;
      3'd5:    tx_byte = 8'h02;
      3'd6:    tx_byte = tx_crc_q[7:0];
      default: tx_byte = tx_crc_q[15:8];
    endcase
  end

  assign stat_o.end_x    = timeout || done9;
  assign stat_o.send     = send;
  assign stat_o.upd      = upd_q;
  assign stat_o.pub      = pub_q;
  assign stat_o.tx_last  = (tx_idx_q == 3'd7);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 8'd1; tmo_q <= 16'd250; gap_q <= 16'd20; age_lim_q <= 16'd10000;
      pub_int_q <= 16'd10000; abs_lim_q <= 16'd30000; probe_q <= 16'd60000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADDR:    addr_q    <= cfg_data_i[7:0];
        CFG_TIMEOUT: tmo_q     <= cfg_data_i;
        CFG_GAP:     gap_q     <= cfg_data_i;
        CFG_AGE:     age_lim_q <= cfg_data_i;
        CFG_PUBINT:  pub_int_q <= cfg_data_i;
        CFG_ABSENT:  abs_lim_q <= cfg_data_i;
        CFG_PROBE:   probe_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) item_q <= in_data_i;
    if (cmd_i.exec && byte_ok && cnt_q < 4'd8) buf_q[cnt_q[2:0]] <= item_q.rx_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0; await_q <= 1'b0; absent_q <= 1'b0; upd_q <= 1'b0; pub_q <= 1'b0;
      cnt_q <= '0; wait_q <= '0; delay_q <= '0; sgr_q <= '0; since_pub_q <= '0;
      err_q <= '0; rx_crc_q <= CRC_INIT; tx_crc_q <= CRC_INIT; tx_idx_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        val_q[i] <= '0; seen_q[i] <= 1'b0; age_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        upd_q <= store;
        pub_q <= 1'b0;
        if (!item_q.op) begin
          sgr_q       <= sat_inc(sgr_q);
          since_pub_q <= sat_inc(since_pub_q);
          for (int i = 0; i < NUM_SLOTS; i++) age_q[i] <= sat_inc(age_q[i]);
          if (await_q) begin
            wait_q <= wait_n;
            if (timeout) err_q <= err_q + 16'd1;
          end else begin
            delay_q <= delay_n;
            if (send) begin
              cnt_q <= '0; wait_q <= '0; await_q <= 1'b1;
              rx_crc_q <= CRC_INIT; tx_crc_q <= CRC_INIT; tx_idx_q <= '0;
            end
          end
        end else if (byte_ok) begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q < 4'd7) rx_crc_q <= crc_byte(rx_crc_q, item_q.rx_byte);
          if (done9 && !good) err_q <= err_q + 16'd1;
          if (store) begin
            val_q[slot_q]  <= word;
            seen_q[slot_q] <= 1'b1;
            age_q[slot_q]  <= '0;
            sgr_q          <= '0;
            absent_q       <= 1'b0;
          end
        end
      end
      if (cmd_i.endx) begin
        await_q  <= 1'b0;
        absent_q <= absent_n;
        if (absent_n) begin
          slot_q <= '0; delay_q <= probe_q;
        end else begin
          slot_q <= slot_n; delay_q <= gap_q;
        end
        pub_q <= pub_now;
        if (pub_now) since_pub_q <= '0;
      end
      if (cmd_i.emit && cmd_i.emit_kind == KIND_TX) begin
        tx_idx_q <= tx_idx_q + 3'd1;
        if (tx_idx_q < 3'd6) tx_crc_q <= crc_byte(tx_crc_q, tx_byte);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Build the next result; the update slot is the one just left behind
  logic [SlotW-1:0] prev_slot;
  assign prev_slot = (slot_q == '0) ? SlotW'(NUM_SLOTS - 1) : slot_q - 1'b1;

  always_comb begin
    out_d              = '0;
    out_d.kind         = cmd_i.emit_kind;
    out_d.meter_absent = absent_q;
    out_d.error_count  = err_q;
    case (cmd_i.emit_kind)
      KIND_TX: begin
        out_d.tx_byte = tx_byte;
        out_d.last    = (tx_idx_q == 3'd7);
      end
      KIND_UPD: begin
        out_d.reg_slot   = prev_slot;
        out_d.value_bits = val_q[prev_slot];
        out_d.last       = !pub_q;
      end
      default: begin
        out_d.active_phases = phases;
        out_d.last          = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/mrmp_ctrl.sv]
// Controller: sequences accept, execute, exchange end and result transfers.
`timescale 1ns / 1ps
module mrmp_ctrl import mrmp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  in_take_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (stat_i.end_x)     state_d = ST_ENDX;
        else if (stat_i.send) state_d = ST_TX;
        else                  state_d = ST_IDLE;
      end
      ST_ENDX: state_d = stat_i.upd ? ST_UPD : ST_PUB;
      ST_TX:   if (stat_i.out_free && stat_i.tx_last) state_d = ST_IDLE;
      ST_UPD:  if (stat_i.out_free) state_d = ST_PUB;
      ST_PUB:  if (!stat_i.pub || stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.emit_kind = KIND_TX;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_ENDX: cmd_o.endx = 1'b1;
      ST_TX:   cmd_o.emit = stat_i.out_free;
      ST_UPD: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.emit_kind = KIND_UPD;
      end
      ST_PUB: begin
        cmd_o.emit      = stat_i.pub && stat_i.out_free;
        cmd_o.emit_kind = KIND_PUB;
      end
      default: ;
    endcase
  end

  assign in_take_o = in_valid_i && in_ready_o;

endmodule

[rtl/modbus_rtu_meter_poller_core.sv]
// Top level: Modbus RTU meter poller, controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t: op, rx_byte)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t)
//  cfg     | input     | cfg_we_i, no wait          | cfg_idx_i, cfg_data_i
//
// One item at a time: accept, an execute state, then back to idle; a tick that sends a
// request also passes through the transmit state for its eight bytes. A completed reply
// or timeout adds an exchange-end state, an update state when a value is stored and a
// publish state whether or not a publish goes out.
// The result register decouples the sides: a stalled out channel holds the sequencer.
// Reset is asynchronous, active low; poll timers, slot and stored values clear at once.
`timescale 1ns / 1ps
module modbus_rtu_meter_poller_core import mrmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_take;

  // Sequencer: owns the state machine only
  mrmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_take_o  (in_take),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: timers, CRC, value store and the result register
  mrmp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_take_i   (in_take),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/mrmp_checker.sv]
// Checker: port-level properties of the poller, bound to the top level.
`timescale 1ns / 1ps
module mrmp_checker import mrmp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken during processing");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_TX |->
      out_data_o.reg_slot == '0 && out_data_o.value_bits == '0 &&
      out_data_o.active_phases == '0)
    else $error("transmit result carries stray fields");

  a_pub_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PUB |-> out_data_o.last)
    else $error("publish not final");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_UPD |->
      out_data_o.reg_slot < SlotW'(NUM_SLOTS))
    else $error("update slot out of range");

endmodule

bind modbus_rtu_meter_poller_core mrmp_checker u_mrmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[sim/tb.sv]
// Testbench for the Modbus RTU meter poller: exchange-level stimulus against a behavioural predictor.
`timescale 1ns / 1ps
module tb;
  import mrmp_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  modbus_rtu_meter_poller_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the poller's registers and state
  logic [7:0]  m_addr;
  logic [15:0] m_tmo, m_gap, m_age_lim, m_pub_int, m_abs_after, m_probe;
  logic [3:0]  m_slot;
  logic        m_waiting;
  logic [7:0]  m_buf [ReplyLen];
  logic [3:0]  m_cnt;
  logic [15:0] m_wait, m_delay, m_since_good;
  logic        m_absent;
  logic [31:0] m_vals [16];
  logic        m_seen [16];
  logic [15:0] m_vage [16];
  logic [15:0] m_since_pub, m_errs;

  out_t expected_q[$];
  out_t pend_q[$];

  int unsigned mismatches = 0, checked = 0, cycles = 0, sent = 0;
  int unsigned updates = 0, publishes = 0, requests = 0;
  int unsigned send_idle = 0, recv_idle = 0; // idle chance per hundred
  bit          hold_outputs = 1'b0;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] crc16(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] meter_reg(input logic [3:0] s);
    logic [15:0] t [16];
    t = '{16'h0000, 16'h0002, 16'h0004, 16'h0006, 16'h0008, 16'h000A, 16'h000C,
          16'h000E, 16'h0010, 16'h0034, 16'h0048, 16'h0156, 16'h0158, 16'h015A,
          16'h015C, 16'h015E};
    return t[s];
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [7:0] tx, input logic [3:0] sl,
                             input logic [31:0] bits, input logic [1:0] ph);
    out_t r;
    r = '0;
    r.kind = k; r.tx_byte = tx; r.reg_slot = sl; r.value_bits = bits; r.active_phases = ph;
    pend_q.push_back(r);
  endtask

  task automatic close_exchange();
    bit fresh;
    logic [1:0] ph;
    m_waiting = 1'b0;
    if (!m_absent && m_since_good >= m_abs_after) m_absent = 1'b1;
    if (m_absent) begin
      m_slot = '0;
      m_delay = m_probe;
      return;
    end
    m_slot = (m_slot == NUM_SLOTS - 1) ? 4'd0 : m_slot + 4'd1;
    m_delay = m_gap;
    if (m_slot == 0) begin
      fresh = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (!m_seen[i] || m_vage[i] > m_age_lim) fresh = 1'b0;
      if (fresh && m_since_pub >= m_pub_int) begin
        ph = '0;
        for (int i = 3; i <= 5; i++)
          if (!m_vals[i][31] && m_vals[i] > FLOAT_ONE) ph++;
        push_result(KIND_PUB, 8'h00, 4'd0, 32'h0, ph);
        m_since_pub = '0;
      end
    end
  endtask

  task automatic judge_reply();
    logic [15:0] c;
    logic [31:0] w;
    c = CRC_INIT;
    for (int i = 0; i < 7; i++) c = crc16(c, m_buf[i]);
    if (m_buf[0] != m_addr || m_buf[1] != FUNC_READ_INPUT || m_buf[2] != BYTE_COUNT ||
        m_buf[7] != c[7:0] || m_buf[8] != c[15:8]) begin
      m_errs++;
    end else begin
      w = {m_buf[3], m_buf[4], m_buf[5], m_buf[6]};
      // drop NaN words silently
      if (!(w[30:23] == 8'hFF && w[22:0] != 0)) begin
        m_vals[m_slot] = w; m_seen[m_slot] = 1'b1; m_vage[m_slot] = '0;
        m_since_good = '0; m_absent = 1'b0;
        push_result(KIND_UPD, 8'h00, m_slot, w, 2'd0);
      end
    end
    close_exchange();
  endtask

  task automatic emit_request();
    logic [7:0] q [8];
    logic [15:0] c, rg;
    rg = meter_reg(m_slot);
    q = '{m_addr, FUNC_READ_INPUT, rg[15:8], rg[7:0], 8'h00, 8'h02, 8'h00, 8'h00};
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc16(c, q[i]);
    q[6] = c[7:0]; q[7] = c[15:8];
    for (int i = 0; i < 8; i++) push_result(KIND_TX, q[i], 4'd0, 32'h0, 2'd0);
    m_cnt = '0; m_wait = '0; m_waiting = 1'b1;
  endtask

  // Advance the shadow state by one input and queue the results it causes
  task automatic predict_poller(input in_t it);
    pend_q.delete();
    if (it.op) begin
      if (m_waiting && m_cnt < ReplyLen) begin
        m_buf[m_cnt] = it.rx_byte;
        m_cnt++;
        if (m_cnt == ReplyLen) judge_reply();
      end
    end else begin
      m_since_good = sat16(m_since_good);
      m_since_pub = sat16(m_since_pub);
      for (int i = 0; i < 16; i++) m_vage[i] = sat16(m_vage[i]);
      if (m_waiting) begin
        m_wait = sat16(m_wait);
        if (m_wait >= m_tmo) begin
          m_errs++;
          close_exchange();
        end
      end else begin
        if (m_delay != 0) m_delay--;
        if (m_delay == 0) emit_request();
      end
    end
    foreach (pend_q[k]) begin
      pend_q[k].last = (k == pend_q.size() - 1);
      pend_q[k].meter_absent = m_absent;
      pend_q[k].error_count = m_errs;
      expected_q.push_back(pend_q[k]);
    end
  endtask

  task automatic model_reset();
    m_addr = 8'd1; m_tmo = 16'd250; m_gap = 16'd20; m_age_lim = 16'd10000;
    m_pub_int = 16'd10000; m_abs_after = 16'd30000; m_probe = 16'd60000;
    m_slot = '0; m_waiting = 1'b0; m_cnt = '0; m_wait = '0; m_delay = '0;
    m_since_good = '0; m_absent = 1'b0; m_since_pub = '0; m_errs = '0;
    for (int i = 0; i < ReplyLen; i++) m_buf[i] = '0;
    for (int i = 0; i < 16; i++) begin
      m_vals[i] = '0; m_seen[i] = 1'b0; m_vage[i] = '0;
    end
  endtask

  // Hold until every expected transfer has come, then let the sequencer settle
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ADDR:    m_addr = val[7:0];
      CFG_TIMEOUT: m_tmo = val;
      CFG_GAP:     m_gap = val;
      CFG_AGE:     m_age_lim = val;
      CFG_PUBINT:  m_pub_int = val;
      CFG_ABSENT:  m_abs_after = val;
      CFG_PROBE:   m_probe = val;
      default: ;
    endcase
  endtask

  // Drive one input transfer and predict it once accepted
  task automatic send_item(input logic op, input logic [7:0] b);
    in_t it;
    it.op = op; it.rx_byte = b;
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_poller(it);
    sent++;
    in_valid_i <= 1'b0;
    // the poller is busy for at least this cycle, so nothing is lost here
    @(posedge clk_i);
  endtask

  task automatic tick(); send_item(1'b0, 8'($urandom_range(255))); endtask

  // Send a reply for the current slot; fault 0 = good, 1 = bad CRC,
  // 2 = wrong address, 3 = wrong function, 4 = wrong count, 5 = short
  task automatic reply_with(input logic [31:0] w, input int fault);
    logic [7:0] r [9];
    logic [15:0] c;
    r = '{m_addr, FUNC_READ_INPUT, BYTE_COUNT, w[31:24], w[23:16], w[15:8], w[7:0],
          8'h00, 8'h00};
    if (fault == 2) r[0] = m_addr ^ (8'd1 << $urandom_range(7));
    if (fault == 3) r[1] = 8'h04 ^ (8'd1 << $urandom_range(7));
    if (fault == 4) r[2] = 8'h04 ^ (8'd1 << $urandom_range(7));
    c = CRC_INIT;
    for (int i = 0; i < 7; i++) c = crc16(c, r[i]);
    r[7] = c[7:0]; r[8] = c[15:8];
    if (fault == 1) r[7 + $urandom_range(1)] ^= 8'd1 << $urandom_range(7);
    for (int i = 0; i < ((fault == 5) ? 4 : 9); i++) send_item(1'b1, r[i]);
  endtask

  // Tick until a request goes out (bounded), then answer it
  task automatic exchange(input logic [31:0] w, input int fault);
    int n;
    n = 0;
    while (!m_waiting && n < 40) begin
      tick();
      n++;
    end
    if (m_waiting) reply_with(w, fault);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return {1'b0, 8'h7F, 23'h0} + $urandom_range(0, 32'h0100_0000);
      1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      2: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    out_t e;
    cycles++;
    if (out_valid_o && out_ready_i) begin
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", out_data_o);
      end else begin
        e = expected_q.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
        end else begin
          if (e.kind == KIND_UPD) updates++;
          if (e.kind == KIND_PUB) publishes++;
          if (e.kind == KIND_TX && e.last) requests++;
        end
      end
    end
    out_ready_i <= !hold_outputs && ($urandom_range(99) >= recv_idle);
    if (cycles > 3000000) begin
      $display("[modbus_rtu_meter_poller_core] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    // first tick sends a request; reply with extremes and the CRC, address, function and count faults
    write_reg(CFG_GAP, 16'd2);
    exchange(32'h0000_0000, 0);
    exchange(32'hFFFF_FFFF, 0);       // NaN: not stored
    exchange(32'h7F80_0000, 0);       // infinity: stored
    exchange(32'h3F80_0001, 1);
    exchange(32'h4000_0000, 2);
    exchange(32'h4000_0000, 3);
    exchange(32'h4000_0000, 4);
    // bytes with no exchange open are ignored
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_timeouts();
    write_reg(CFG_TIMEOUT, 16'd0);    // zero timeout: first tick expires
    write_reg(CFG_GAP, 16'd0);
    exchange(32'h0, 5);
    tick(); tick(); tick();
    write_reg(CFG_TIMEOUT, 16'd3);
    for (int i = 0; i < 8; i++) tick();
  endtask

  task automatic test_absent();
    write_reg(CFG_ABSENT, 16'd1);
    write_reg(CFG_PROBE, 16'd2);
    for (int i = 0; i < 12; i++) tick();
    exchange(32'h4120_0000, 0);       // good reply clears absence
    write_reg(CFG_PROBE, 16'd0);
    write_reg(CFG_ABSENT, 16'hFFFF);
    for (int i = 0; i < 6; i++) tick();
  endtask

  task automatic test_sweeps(input int items);
    int fault;
    while (sent < items) begin
      fault = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(99) < 5) send_item(1'b1, 8'($urandom_range(255)));
      exchange(rand_word(), fault);
    end
  endtask

  task automatic test_publish();
    write_reg(CFG_ADDR, 16'h00FF);
    write_reg(CFG_TIMEOUT, 16'd2);
    write_reg(CFG_GAP, 16'd1);
    write_reg(CFG_AGE, 16'hFFFF);
    write_reg(CFG_PUBINT, 16'd0);
    write_reg(CFG_ABSENT, 16'hFFFF);
    send_idle = 8; recv_idle = 56;
    test_sweeps(sent + 70);
    // sender pauses until the receiver side is empty
    drain();
    write_reg(CFG_ADDR, 16'h0000);
    write_reg(CFG_AGE, 16'd1);        // freshness rarely holds: publishes suppressed
    write_reg(CFG_PUBINT, 16'hFFFF);
    send_idle = 56; recv_idle = 8;
    test_sweeps(sent + 25);
    write_reg(CFG_AGE, 16'd400);
    write_reg(CFG_PUBINT, 16'd30);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_GAP, 16'd0);
    send_idle = 0; recv_idle = 0;
    test_sweeps(sent + 50);
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 8; recv_idle = 56;
    test_directed();
    test_timeouts();
    test_absent();
    test_publish();
    drain();
    $display("covered %0d inputs: %0d requests, %0d updates, %0d publishes", sent, requests,
             updates, publishes);
    $display("faults, NaN words, timeouts, absence and all register extremes exercised");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[modbus_rtu_meter_poller_core] OK");
    end else begin
      $display("[modbus_rtu_meter_poller_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mrmp_pkg.sv
rtl/mrmp_datapath.sv
rtl/mrmp_ctrl.sv
rtl/modbus_rtu_meter_poller_core.sv
rtl/mrmp_checker.sv
sim/tb.sv
